>>> design/nearest_palette_color_search_assert.svh
// Assertion macros used by the checker file of the palette search block
`ifndef NEAREST_PALETTE_COLOR_SEARCH_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_ASSERT_SVH

// Same-cycle implication, quiet while reset is asserted
`define NPCS_ASSERT_SAME(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, quiet while reset is asserted
`define NPCS_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error("%m: next-cycle check failed");

`endif

>>> design/npcs_pkg.sv
// Package: word types, codes and control structs of the palette search block
`timescale 1ns / 1ps

package npcs_pkg;

	// Default palette depth and the largest count an 8-bit index can reach
	localparam int PALETTE_DEPTH_DEF = 256;
	localparam int INDEX_LIMIT       = 256;

	localparam int COUNT_W = 9;
	localparam int DIST_W  = 18;

	// Command word opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic       opcode;
		logic [7:0] entry_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} cmd_word_t;

	typedef struct packed {
		logic [7:0]        nearest_index;
		logic [DIST_W-1:0] min_distance;
	} res_word_t;

	// Controller to datapath commands
	typedef struct packed {
		logic write;
		logic load;
		logic issue;
	} dp_ctrl_t;

	// Datapath to controller status
	typedef struct packed {
		logic at_last;
		logic done;
	} dp_stat_t;

endpackage

>>> design/npcs_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module npcs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/npcs_datapath.sv
// Datapath: palette memory, scan counter, distance pipeline and best-match tracker
`timescale 1ns / 1ps

module npcs_datapath #(
	parameter int PALETTE_DEPTH = npcs_pkg::PALETTE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  npcs_pkg::dp_ctrl_t           ctrl,
	output npcs_pkg::dp_stat_t           stat,
	input  npcs_pkg::cmd_word_t          item,
	input  logic                         cfg_we,
	input  logic [npcs_pkg::COUNT_W-1:0] cfg_wdata,
	output npcs_pkg::res_word_t          result,
	output logic                         result_valid
);

	import npcs_pkg::*;

	localparam int AW  = $clog2(PALETTE_DEPTH);
	localparam int LIM = (PALETTE_DEPTH < INDEX_LIMIT) ? PALETTE_DEPTH : INDEX_LIMIT;
	localparam int SW  = $clog2(LIM);

	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_eff;
	logic [SW-1:0]      last_q;
	logic [SW-1:0]      scan_q;
	logic [7:0]         qr_q, qg_q, qb_q;
	logic               wr_ok;
	logic [23:0]        rd_entry;

	logic               v_s1, last_s1;
	logic [SW-1:0]      idx_s1;
	logic               v_s2, last_s2;
	logic [SW-1:0]      idx_s2;
	logic [DIST_W-1:0]  dist_s2;

	logic [7:0]         dr, dg, db;
	logic [15:0]        sr, sg, sb;
	logic [DIST_W-1:0]  dist_sum;

	logic [SW-1:0]      best_idx_q, nxt_idx;
	logic [DIST_W-1:0]  best_d_q, nxt_d;
	logic               take;

	// Hold the palette count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_W'(1);
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	// Clamp the count to one and to the smaller of the palette depth and the index limit
	always_comb begin
		if (count_q == '0) begin
			count_eff = COUNT_W'(1);
		end else if (count_q > COUNT_W'(LIM)) begin
			count_eff = COUNT_W'(LIM);
		end else begin
			count_eff = count_q;
		end
	end

	// Drop writes beyond the palette depth
	assign wr_ok = (32'(item.entry_index) < PALETTE_DEPTH);

	npcs_ram #(
		.WIDTH (24),
		.DEPTH (PALETTE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ctrl.write && wr_ok),
		.waddr (AW'(item.entry_index)),
		.wdata ({item.red, item.green, item.blue}),
		.re    (ctrl.issue),
		.raddr (AW'(scan_q)),
		.rdata (rd_entry)
	);

	// Latch the query color and scan limit; advance the scan address
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			qr_q   <= item.red;
			qg_q   <= item.green;
			qb_q   <= item.blue;
			last_q <= SW'(count_eff - COUNT_W'(1));
			scan_q <= '0;
		end else if (ctrl.issue) begin
			scan_q <= scan_q + SW'(1);
		end
	end

	assign stat.at_last = (scan_q == last_q);

	// Squared distance of the entry just read
	always_comb begin
		dr       = (rd_entry[23:16] > qr_q) ? (rd_entry[23:16] - qr_q) : (qr_q - rd_entry[23:16]);
		dg       = (rd_entry[15:8]  > qg_q) ? (rd_entry[15:8]  - qg_q) : (qg_q - rd_entry[15:8]);
		db       = (rd_entry[7:0]   > qb_q) ? (rd_entry[7:0]   - qb_q) : (qb_q - rd_entry[7:0]);
		sr       = dr * dr;
		sg       = dg * dg;
		sb       = db * db;
		dist_sum = DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
	end

	// Advance pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ctrl.issue;
			v_s2 <= v_s1;
		end
	end

	// Advance pipeline payload
	always_ff @(posedge clk) begin
		idx_s1  <= scan_q;
		last_s1 <= (scan_q == last_q);
		idx_s2  <= idx_s1;
		last_s2 <= last_s1;
		dist_s2 <= dist_sum;
	end

	// Replace the best only on a strictly smaller distance; entry zero seeds it
	always_comb begin
		take    = v_s2 && ((idx_s2 == '0) || (dist_s2 < best_d_q));
		nxt_idx = take ? idx_s2 : best_idx_q;
		nxt_d   = take ? dist_s2 : best_d_q;
	end

	always_ff @(posedge clk) begin
		best_idx_q <= nxt_idx;
		best_d_q   <= nxt_d;
	end

	assign stat.done = v_s2 && last_s2;

	// Register the result word and its strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= stat.done;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			result.nearest_index <= 8'(nxt_idx);
			result.min_distance  <= nxt_d;
		end
	end

endmodule

>>> design/npcs_ctrl.sv
// Controller: command acceptance and scan sequencing state machine
`timescale 1ns / 1ps

module npcs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                opcode,
	output logic                busy,
	output npcs_pkg::dp_ctrl_t  ctrl,
	input  npcs_pkg::dp_stat_t  stat
);

	import npcs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// Decode commands and next state
	always_comb begin
		state_d    = state_q;
		ctrl.write = 1'b0;
		ctrl.load  = 1'b0;
		ctrl.issue = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (opcode == OP_WRITE)) begin
					ctrl.write = 1'b1;
				end else if (accept) begin
					ctrl.load = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				ctrl.issue = 1'b1;
				if (stat.at_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (stat.done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> design/nearest_palette_color_search.sv
// Top level: nearest palette color search by squared RGB distance
//
//   port group               dir  handshake
//   command                  in   start && !busy accepts the word
//   result                   out  result_valid marks the word for one cycle
//   cfg_we / cfg_wdata       in   palette_count written when cfg_we is high
//
// A write word raises no busy.
// A query word keeps busy high while n entries are scanned and the pipeline drains;
// its result shows as busy falls. n is the clamped palette count, at most the lesser
// of PALETTE_DEPTH and 256; the memory's single read port walks one entry per cycle.
// Reset clears the controller, the pipeline flags and sets palette_count to 1;
// palette contents are undefined until written.
// The result strobe cannot be stalled; the next word may be accepted while it shows.
`timescale 1ns / 1ps

module nearest_palette_color_search #(
	parameter int PALETTE_DEPTH = npcs_pkg::PALETTE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  npcs_pkg::cmd_word_t          command,
	output npcs_pkg::res_word_t          result,
	output logic                         result_valid,
	input  logic                         cfg_we,
	input  logic [npcs_pkg::COUNT_W-1:0] cfg_wdata
);

	import npcs_pkg::*;

	dp_ctrl_t ctrl;
	dp_stat_t stat;

	npcs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (command.opcode),
		.busy   (busy),
		.ctrl   (ctrl),
		.stat   (stat)
	);

	npcs_datapath #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.stat         (stat),
		.item         (command),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

>>> design/npcs_checker.sv
// Checker: port-level timing checks of the palette search block, bound to the top
`timescale 1ns / 1ps
`include "nearest_palette_color_search_assert.svh"

module npcs_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input npcs_pkg::cmd_word_t command,
	input npcs_pkg::res_word_t result,
	input logic                result_valid
);

	import npcs_pkg::*;

	logic acc_query, acc_write;

	assign acc_query = start && !busy && (command.opcode == OP_QUERY);
	assign acc_write = start && !busy && (command.opcode == OP_WRITE);

	// A query holds the block busy on the next cycle
	`NPCS_ASSERT_NEXT(a_query_busy, clk, arst_n, acc_query, busy)
	// A write produces no result word
	`NPCS_ASSERT_NEXT(a_write_silent, clk, arst_n, acc_write, !result_valid)
	// The result word shows once the block is free again
	`NPCS_ASSERT_SAME(a_result_idle, clk, arst_n, result_valid, !busy)
	// Result strobe lasts a single cycle
	`NPCS_ASSERT_NEXT(a_result_pulse, clk, arst_n, result_valid, !result_valid)
	// Distance stays within the largest squared RGB span
	`NPCS_ASSERT_SAME(a_dist_range, clk, arst_n, result_valid, result.min_distance <= DIST_W'(195075))

endmodule

bind nearest_palette_color_search npcs_checker u_npcs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.command      (command),
	.result       (result),
	.result_valid (result_valid)
);
